/* sv/rrtt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the round-robin task table.
// Holds the request and response transfer structs; no dependencies.

package rrtt_pkg;

    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned TAG_W   = 32;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_KILL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEND  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCHED = 3'd4;

    // Slot states
    localparam logic [STATE_W-1:0] ST_READY    = 3'd0;
    localparam logic [STATE_W-1:0] ST_PENDING  = 3'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd2;
    localparam logic [STATE_W-1:0] ST_INACTIVE = 3'd3;

    // Response status
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] task_id;
        logic [TAG_W-1:0]  entry_code;
        logic [TAG_W-1:0]  entry_arg;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] result_slot;
        logic [TAG_W-1:0]  dispatch_code;
        logic [TAG_W-1:0]  dispatch_arg;
        logic              current_valid;
        logic [SLOT_W-1:0] current_slot;
    } rsp_t;

endpackage

/* sv/round_robin_task_table_core.sv */
`timescale 1ns / 1ps
// Round-robin task table: slot states, tags and a one-slot-per-cycle scanner.
// Depends on rrtt_pkg for the transfer structs and the mode and state codes.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------
//  req     | in        | req_valid / req_ready   | rrtt_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready   | rrtt_pkg::rsp_t
//
// Kill, pend, ready and unknown modes go straight to S_FINISH, which raises rsp_valid.
// Add and schedule test one slot a cycle in a shared unit until a slot hits or all
// slots have been tested, then go to S_FINISH. S_FINISH waits while a response is held.
// req_ready is high only when idle, so each request passes S_FINISH before the next.
// A held response does not stop the next request from being taken.
// After reset every slot is free and READY and the current slot is the last one.

module round_robin_task_table_core #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rrtt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rrtt_pkg::rsp_t rsp
);

    import rrtt_pkg::*;

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } fsm_t;

    fsm_t                fsm_reg;
    logic [STATE_W-1:0]  slot_state_reg [NUM_SLOTS];
    logic                occupied_reg   [NUM_SLOTS];
    logic [IDX_W-1:0]    cur_reg;
    logic                present_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                status_reg;
    logic [SLOT_W-1:0]   rslot_reg;
    logic [TAG_W-1:0]    code_reg;
    logic [TAG_W-1:0]    arg_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    // Tag memories: written by add, read at the scan pointer.
    logic [TAG_W-1:0]    code_mem [NUM_SLOTS];
    logic [TAG_W-1:0]    arg_mem  [NUM_SLOTS];
    logic [TAG_W-1:0]    rd_code_reg;
    logic [TAG_W-1:0]    rd_arg_reg;

    logic                is_add;
    logic                hit;
    logic [IDX_W-1:0]    ptr_next;
    logic                mem_we;
    logic                id_ok;
    logic [IDX_W-1:0]    id_idx;
    logic [STATE_W-1:0]  id_state;
    logic                rsp_free;
    logic [TAG_W-1:0]    dispatch_code_next;
    logic [TAG_W-1:0]    dispatch_arg_next;

    assign req_ready = (fsm_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Shared scan unit: test the slot under the pointer and step round the table.
    always_comb
    begin
        is_add   = (mode_reg == MODE_ADD);
        hit      = is_add ? !occupied_reg[ptr_reg]
                          : (occupied_reg[ptr_reg] && (slot_state_reg[ptr_reg] == ST_READY));
        ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        mem_we   = (fsm_reg == S_SCAN) && is_add && hit;
    end

    always_comb
    begin
        id_ok    = ({1'b0, req.task_id} < (SLOT_W + 1)'(NUM_SLOTS));
        id_idx   = req.task_id[IDX_W-1:0];
        id_state = slot_state_reg[id_idx];
        rsp_free = !rsp_valid_reg || rsp_ready;
        if ((mode_reg == MODE_SCHED) && (status_reg == STAT_DONE))
        begin
            dispatch_code_next = rd_code_reg;
            dispatch_arg_next  = rd_arg_reg;
        end
        else
        begin
            dispatch_code_next = '0;
            dispatch_arg_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            code_mem[ptr_reg] <= code_reg;
            arg_mem[ptr_reg]  <= arg_reg;
        end
        rd_code_reg <= code_mem[ptr_reg];
        rd_arg_reg  <= arg_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= ST_READY;
                occupied_reg[i]   <= 1'b0;
            end
            cur_reg       <= LAST_IDX;
            present_reg   <= 1'b1;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            mode_reg      <= MODE_ADD;
            status_reg    <= STAT_REFUSED;
            rslot_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // In S_FINISH an accepted response is replaced by the next one below.
            if (rsp_ready && (fsm_reg != S_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (fsm_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        mode_reg   <= req.mode;
                        code_reg   <= req.entry_code;
                        arg_reg    <= req.entry_arg;
                        status_reg <= STAT_REFUSED;
                        rslot_reg  <= '0;
                        cnt_reg    <= '0;
                        fsm_reg    <= S_FINISH;
                        case (req.mode)
                            MODE_ADD:
                            begin
                                ptr_reg <= '0;
                                fsm_reg <= S_SCAN;
                            end
                            MODE_SCHED:
                            begin
                                if (present_reg)
                                begin
                                    ptr_reg <= (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
                                end
                                else
                                begin
                                    ptr_reg <= '0;
                                end
                                fsm_reg <= S_SCAN;
                            end
                            MODE_KILL:
                            begin
                                if (id_ok && (id_state inside {ST_READY, ST_RUNNING}))
                                begin
                                    slot_state_reg[id_idx] <= ST_INACTIVE;
                                    status_reg             <= STAT_DONE;
                                end
                            end
                            MODE_PEND:
                            begin
                                if (id_ok && (id_state == ST_RUNNING))
                                begin
                                    slot_state_reg[id_idx] <= ST_PENDING;
                                    status_reg             <= STAT_DONE;
                                end
                            end
                            MODE_READY:
                            begin
                                if (id_ok &&
                                    (id_state inside {ST_PENDING, ST_RUNNING, ST_INACTIVE}))
                                begin
                                    slot_state_reg[id_idx] <= ST_READY;
                                    status_reg             <= STAT_DONE;
                                end
                            end
                            default:
                            begin
                                // Unknown modes are refused and leave the table alone.
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        status_reg <= STAT_DONE;
                        rslot_reg  <= SLOT_W'(ptr_reg);
                        if (is_add)
                        begin
                            // A zero code tag is stored but leaves the slot free.
                            occupied_reg[ptr_reg] <= (code_reg != '0);
                        end
                        else
                        begin
                            cur_reg     <= ptr_reg;
                            present_reg <= 1'b1;
                        end
                        // The pointer stays put so the tag read settles on this slot.
                        fsm_reg <= S_FINISH;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        if (!is_add)
                        begin
                            present_reg <= 1'b0;
                            cur_reg     <= '0;
                        end
                        fsm_reg <= S_FINISH;
                    end
                    else
                    begin
                        ptr_reg <= ptr_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg         <= 1'b1;
                        rsp_reg.status        <= status_reg;
                        rsp_reg.result_slot   <= rslot_reg;
                        rsp_reg.dispatch_code <= dispatch_code_next;
                        rsp_reg.dispatch_arg  <= dispatch_arg_next;
                        rsp_reg.current_valid <= present_reg;
                        rsp_reg.current_slot  <= present_reg ? SLOT_W'(cur_reg) : '0;
                        fsm_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    fsm_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/rrtt_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the round-robin task table, bound to the top level.
// Depends on rrtt_pkg for the transfer structs and status codes.

module rrtt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input rrtt_pkg::rsp_t rsp
);

    import rrtt_pkg::*;

    // Only one request is in flight, so the core is busy right after a transfer.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a previous one was in flight");

    // A refused request never hands out tags.
    a_refused_no_tags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_REFUSED)) |->
        ((rsp.dispatch_code == '0) && (rsp.dispatch_arg == '0)))
        else $error("refused response carries dispatch tags");

    // Without a current task the reported slot reads as zero.
    a_no_current_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.current_valid) |-> (rsp.current_slot == '0))
        else $error("current slot nonzero while no current task is held");

    // A dispatched task becomes the current one.
    a_dispatch_current: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_DONE) && (rsp.dispatch_code != '0)) |->
        (rsp.current_valid && (rsp.current_slot == rsp.result_slot)))
        else $error("dispatched slot does not match the current slot");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

endmodule

bind round_robin_task_table_core rrtt_checker u_rrtt_checker (.*);
